// File: rtl/trb_pkg.sv
package trb_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int TRB_DEPTH        = 1024;
    localparam int TRB_CHANNELS     = 4;
    localparam int TRB_PAYLOAD_BITS = 64;
    localparam int TRB_TIME_BITS    = 32;

    // Fixed port widths
    localparam int OP_W           = 2;
    localparam int CH_PORT_W      = 2;
    localparam int TIME_PORT_W    = 32;
    localparam int PAYLOAD_PORT_W = 64;
    localparam int STATUS_W       = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_PLAY   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WITHIN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PAST_END = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_REC_CHK,
        S_REC_END,
        S_PLAY_LAST,
        S_UP_CHK,
        S_DN_RD,
        S_DN_CHK,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// File: rtl/timestamped_rewind_buffer.sv
// Time-stamped rewind buffer: one time-ordered stack of entries per channel, all
// held in a single entry memory (time and payload side by side) with one read and
// one write port. One beat is taken at a time; o_stall stays high until its work
// is done. A record checks entries during truncation: each entry dropped, and the
// surviving entry below them when there is one. A play on a channel with at least
// two entries reads the last entry and then walks the cursor up or down. Every
// step of truncation and of the cursor walk is one read of the entry memory. A
// finished result sits in the output register until taken, and a new beat is
// accepted meanwhile; that beat's result waits in the controller, with o_stall
// high, until the register frees up.
module timestamped_rewind_buffer #(
    parameter int DEPTH        = trb_pkg::TRB_DEPTH,
    parameter int CHANNELS     = trb_pkg::TRB_CHANNELS,
    parameter int PAYLOAD_BITS = trb_pkg::TRB_PAYLOAD_BITS,
    parameter int TIME_BITS    = trb_pkg::TRB_TIME_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [trb_pkg::OP_W-1:0]               i_operation,
    input  logic [trb_pkg::CH_PORT_W-1:0]          i_channel,
    input  logic [trb_pkg::TIME_PORT_W-1:0]        i_timestamp,
    input  logic [trb_pkg::PAYLOAD_PORT_W-1:0]     i_payload_in,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [trb_pkg::STATUS_W-1:0]           o_status,
    output logic [trb_pkg::TIME_PORT_W-1:0]        o_entry_time,
    output logic [trb_pkg::PAYLOAD_PORT_W-1:0]     o_payload_out
);
    import trb_pkg::*;

    localparam int TW     = (TIME_BITS < TIME_PORT_W) ? TIME_BITS : TIME_PORT_W;
    localparam int PB     = PAYLOAD_BITS;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int ADDR_W = CH_W + IDX_W;

    t_mem_ctl                  mem_ctl;
    logic [ADDR_W-1:0]         rd_addr, wr_addr;
    logic [TW-1:0]             wr_time, rd_time;
    logic [PB-1:0]             wr_payload, rd_payload;
    logic                      out_free, out_load;
    logic [STATUS_W-1:0]       res_status;
    logic [TIME_PORT_W-1:0]    res_time;
    logic [PAYLOAD_PORT_W-1:0] res_payload;

    trb_ctrl #(
        .DEPTH    (DEPTH),
        .CHANNELS (CHANNELS),
        .TW       (TW),
        .PB       (PB),
        .CH_W     (CH_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_operation   (i_operation),
        .i_channel     (i_channel),
        .i_timestamp   (i_timestamp),
        .i_payload_in  (i_payload_in),
        .o_stall       (o_stall),
        .o_mem_ctl     (mem_ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_wr_time     (wr_time),
        .o_wr_payload  (wr_payload),
        .i_rd_time     (rd_time),
        .i_rd_payload  (rd_payload),
        .i_out_free    (out_free),
        .o_load        (out_load),
        .o_res_status  (res_status),
        .o_res_time    (res_time),
        .o_res_payload (res_payload)
    );

    trb_store #(
        .ADDR_W (ADDR_W),
        .TW     (TW),
        .PB     (PB)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_rd_addr    (rd_addr),
        .i_wr_addr    (wr_addr),
        .i_wr_time    (wr_time),
        .i_wr_payload (wr_payload),
        .o_rd_time    (rd_time),
        .o_rd_payload (rd_payload)
    );

    trb_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (out_load),
        .i_status      (res_status),
        .i_entry_time  (res_time),
        .i_payload     (res_payload),
        .i_stall       (i_stall),
        .o_free        (out_free),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_time  (o_entry_time),
        .o_payload_out (o_payload_out)
    );

endmodule

// File: rtl/trb_store.sv
module trb_store #(
    parameter int ADDR_W = 12,
    parameter int TW     = 32,
    parameter int PB     = 64
) (
    input  logic                i_clk,
    input  trb_pkg::t_mem_ctl   i_ctl,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic [TW-1:0]       i_wr_time,
    input  logic [PB-1:0]       i_wr_payload,
    output logic [TW-1:0]       o_rd_time,
    output logic [PB-1:0]       o_rd_payload
);
    import trb_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [TW-1:0] r_time_mem [MEM_DEPTH];
    logic [PB-1:0] r_payload_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_time_mem[i_wr_addr]    <= i_wr_time;
            r_payload_mem[i_wr_addr] <= i_wr_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_time    <= r_time_mem[i_rd_addr];
            o_rd_payload <= r_payload_mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/trb_out.sv
module trb_out (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic [trb_pkg::STATUS_W-1:0]           i_status,
    input  logic [trb_pkg::TIME_PORT_W-1:0]        i_entry_time,
    input  logic [trb_pkg::PAYLOAD_PORT_W-1:0]     i_payload,
    input  logic                                   i_stall,
    output logic                                   o_free,
    output logic                                   o_valid,
    output logic [trb_pkg::STATUS_W-1:0]           o_status,
    output logic [trb_pkg::TIME_PORT_W-1:0]        o_entry_time,
    output logic [trb_pkg::PAYLOAD_PORT_W-1:0]     o_payload_out
);
    import trb_pkg::*;

    logic r_valid;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_status      <= i_status;
            o_entry_time  <= i_entry_time;
            o_payload_out <= i_payload;
        end
    end

endmodule

// File: rtl/trb_ctrl.sv
module trb_ctrl #(
    parameter int DEPTH    = 1024,
    parameter int CHANNELS = 4,
    parameter int TW       = 32,
    parameter int PB       = 64,
    parameter int CH_W     = 2,
    parameter int IDX_W    = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [trb_pkg::OP_W-1:0]               i_operation,
    input  logic [trb_pkg::CH_PORT_W-1:0]          i_channel,
    input  logic [trb_pkg::TIME_PORT_W-1:0]        i_timestamp,
    input  logic [trb_pkg::PAYLOAD_PORT_W-1:0]     i_payload_in,
    output logic                                   o_stall,
    output trb_pkg::t_mem_ctl                      o_mem_ctl,
    output logic [CH_W+IDX_W-1:0]                  o_rd_addr,
    output logic [CH_W+IDX_W-1:0]                  o_wr_addr,
    output logic [TW-1:0]                          o_wr_time,
    output logic [PB-1:0]                          o_wr_payload,
    input  logic [TW-1:0]                          i_rd_time,
    input  logic [PB-1:0]                          i_rd_payload,
    input  logic                                   i_out_free,
    output logic                                   o_load,
    output logic [trb_pkg::STATUS_W-1:0]           o_res_status,
    output logic [trb_pkg::TIME_PORT_W-1:0]        o_res_time,
    output logic [trb_pkg::PAYLOAD_PORT_W-1:0]     o_res_payload
);
    import trb_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CUR_W = CNT_W + 1;
    localparam logic signed [CUR_W-1:0] C_ZERO = 0;
    localparam logic signed [CUR_W-1:0] C_ONE  = 1;
    localparam logic signed [CUR_W-1:0] C_TWO  = 2;

    t_state r_state, n_state;

    logic [OP_W-1:0]  r_op;
    logic [CH_W-1:0]  r_ch;
    logic             r_ch_ok;
    logic [TW-1:0]    r_t;
    logic [PB-1:0]    r_p;

    logic [CNT_W-1:0]        r_n, n_n;
    logic signed [CUR_W-1:0] r_s, n_s;
    logic signed [CUR_W-1:0] r_ic, n_ic;
    logic                    r_le, n_le;

    logic [CNT_W-1:0]        r_count [CHANNELS];
    logic signed [CUR_W-1:0] r_cursor [CHANNELS];

    logic [STATUS_W-1:0]       r_res_status, n_res_status;
    logic [TIME_PORT_W-1:0]    r_res_time, n_res_time;
    logic [PAYLOAD_PORT_W-1:0] r_res_payload, n_res_payload;
    logic                      res_we;

    logic [CNT_W-1:0]        cnt_sel;
    logic signed [CUR_W-1:0] cur_sel, s_sig, clamped;
    logic signed [CUR_W-1:0] rd_pos;
    logic                    count_we, clear_all, cursor_we;
    logic [CNT_W-1:0]        count_wdata;

    logic is_rec, is_play, is_clear;
    logic rec_hit, up_hit, dn_hit;

    assign is_clear = (r_op == OP_CLEAR);
    assign is_rec   = (r_op == OP_RECORD) && r_ch_ok;
    assign is_play  = (r_op == OP_PLAY) && r_ch_ok;

    assign cnt_sel = r_count[r_ch];
    assign cur_sel = r_cursor[r_ch];
    assign s_sig   = $signed({1'b0, cnt_sel});
    assign clamped = (cur_sel > s_sig - C_ONE) ? (s_sig - C_ONE) : cur_sel;

    assign rec_hit = (i_rd_time >= r_t);
    assign up_hit  = (i_rd_time <= r_t);
    assign dn_hit  = (i_rd_time > r_t);

    assign o_stall      = (r_state != S_IDLE) || !i_rst_n;
    assign o_rd_addr    = {r_ch, rd_pos[IDX_W-1:0]};
    assign o_wr_addr    = {r_ch, r_n[IDX_W-1:0]};
    assign o_wr_time    = r_t;
    assign o_wr_payload = r_p;
    assign o_load        = (r_state == S_OUT) && i_out_free;
    assign o_res_status  = r_res_status;
    assign o_res_time    = r_res_time;
    assign o_res_payload = r_res_payload;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_START;
            end
            S_START: begin
                if (is_rec) begin
                    n_state = (cnt_sel == '0) ? S_REC_END : S_REC_CHK;
                end else if (is_play) begin
                    n_state = (s_sig < C_TWO) ? S_OUT : S_PLAY_LAST;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_REC_CHK: begin
                if (!rec_hit || r_n == CNT_W'(1)) n_state = S_REC_END;
            end
            S_REC_END:   n_state = S_OUT;
            S_PLAY_LAST: begin
                n_state = (r_ic + C_ONE < r_s - C_ONE) ? S_UP_CHK : S_DN_RD;
            end
            S_UP_CHK: begin
                if (!up_hit || !(r_ic + C_TWO < r_s - C_ONE)) n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (r_ic > C_ZERO)       n_state = S_DN_CHK;
                else if (r_ic == C_ZERO) n_state = S_FIN;
                else                     n_state = S_OUT;
            end
            S_DN_CHK: begin
                if (!dn_hit)                   n_state = S_OUT;
                else if (r_ic - C_ONE == C_ZERO) n_state = S_FIN;
            end
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        o_mem_ctl     = '0;
        rd_pos        = C_ZERO;
        n_n           = r_n;
        n_s           = r_s;
        n_ic          = r_ic;
        n_le          = r_le;
        n_res_status  = r_res_status;
        n_res_time    = r_res_time;
        n_res_payload = r_res_payload;
        res_we        = 1'b0;
        count_we      = 1'b0;
        count_wdata   = r_n;
        clear_all     = 1'b0;
        cursor_we     = 1'b0;
        case (r_state)
            S_START: begin
                res_we        = 1'b1;
                n_res_time    = '0;
                n_res_payload = '0;
                n_res_status  = ST_NO_FRAME;
                if (is_clear) begin
                    clear_all    = 1'b1;
                    n_res_status = ST_ACCEPTED;
                end else if (is_rec) begin
                    n_n             = cnt_sel;
                    rd_pos          = s_sig - C_ONE;
                    o_mem_ctl.rd_en = (cnt_sel != '0);
                end else if (is_play) begin
                    n_s             = s_sig;
                    n_ic            = clamped;
                    rd_pos          = s_sig - C_ONE;
                    o_mem_ctl.rd_en = !(s_sig < C_TWO);
                end
            end
            S_REC_CHK: begin
                if (rec_hit) begin
                    n_n             = r_n - CNT_W'(1);
                    rd_pos          = $signed({1'b0, r_n}) - C_TWO;
                    o_mem_ctl.rd_en = (r_n != CNT_W'(1));
                end
            end
            S_REC_END: begin
                res_we   = 1'b1;
                count_we = 1'b1;
                if (r_n >= CNT_W'(DEPTH)) begin
                    n_res_status = ST_DROPPED;
                    count_wdata  = r_n;
                end else begin
                    n_res_status    = ST_ACCEPTED;
                    count_wdata     = r_n + CNT_W'(1);
                    o_mem_ctl.wr_en = 1'b1;
                end
            end
            S_PLAY_LAST: begin
                n_le            = (r_t <= i_rd_time);
                rd_pos          = r_ic + C_ONE;
                o_mem_ctl.rd_en = (r_ic + C_ONE < r_s - C_ONE);
            end
            S_UP_CHK: begin
                if (up_hit) begin
                    n_ic            = r_ic + C_ONE;
                    rd_pos          = r_ic + C_TWO;
                    o_mem_ctl.rd_en = (r_ic + C_TWO < r_s - C_ONE);
                end
            end
            S_DN_RD: begin
                rd_pos          = r_ic;
                o_mem_ctl.rd_en = (r_ic >= C_ZERO);
            end
            S_DN_CHK: begin
                if (dn_hit) begin
                    n_ic            = r_ic - C_ONE;
                    rd_pos          = r_ic - C_ONE;
                    o_mem_ctl.rd_en = 1'b1;
                end else begin
                    res_we        = 1'b1;
                    n_res_status  = r_le ? ST_WITHIN : ST_PAST_END;
                    n_res_time    = TIME_PORT_W'(i_rd_time);
                    n_res_payload = PAYLOAD_PORT_W'(i_rd_payload);
                end
            end
            S_FIN: begin
                res_we        = 1'b1;
                n_res_status  = r_le ? ST_WITHIN : ST_PAST_END;
                n_res_time    = TIME_PORT_W'(i_rd_time);
                n_res_payload = PAYLOAD_PORT_W'(i_rd_payload);
            end
            S_OUT: begin
                // cursor keeps the clamp even when play finds no frame
                cursor_we = is_play && i_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i]  <= '0;
                r_cursor[i] <= C_ZERO;
            end
        end else begin
            r_state <= n_state;
            if (clear_all) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_count[i]  <= '0;
                    r_cursor[i] <= C_ZERO;
                end
            end
            if (count_we)  r_count[r_ch]  <= count_wdata;
            if (cursor_we) r_cursor[r_ch] <= r_ic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op    <= i_operation;
            r_ch    <= CH_W'(i_channel);
            r_ch_ok <= (32'(i_channel) < CHANNELS);
            r_t     <= TW'(i_timestamp);
            r_p     <= PB'(i_payload_in);
        end
        r_n  <= n_n;
        r_s  <= n_s;
        r_ic <= n_ic;
        r_le <= n_le;
        if (res_we) begin
            r_res_status  <= n_res_status;
            r_res_time    <= n_res_time;
            r_res_payload <= n_res_payload;
        end
    end

endmodule

// File: rtl/trb_checker.sv
module trb_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic [trb_pkg::OP_W-1:0]               i_operation,
    input logic [trb_pkg::CH_PORT_W-1:0]          i_channel,
    input logic [trb_pkg::TIME_PORT_W-1:0]        i_timestamp,
    input logic [trb_pkg::PAYLOAD_PORT_W-1:0]     i_payload_in,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic [trb_pkg::STATUS_W-1:0]           o_status,
    input logic [trb_pkg::TIME_PORT_W-1:0]        o_entry_time,
    input logic [trb_pkg::PAYLOAD_PORT_W-1:0]     o_payload_out
);
    import trb_pkg::*;

    // a held result beat does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_entry_time) && $stable(o_payload_out))
        else $error("output beat changed while stalled");

    // one beat at a time: the block is busy right after taking one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while previous beat still in work");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_DROPPED)
        else $error("illegal status code");

    // only a play hit carries an entry
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ACCEPTED || o_status == ST_NO_FRAME
            || o_status == ST_DROPPED) |-> o_entry_time == '0 && o_payload_out == '0)
        else $error("nonzero entry fields on a non-play result");

endmodule

bind timestamped_rewind_buffer trb_checker u_trb_checker (.*);

// File: sim/tb_timestamped_rewind_buffer.sv
`timescale 1ns / 100ps

module tb_timestamped_rewind_buffer;
    import trb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NUM_CH = TRB_CHANNELS;
    localparam int NUM_ENTRIES = TRB_DEPTH;
    localparam int DEEP_FILL = 128;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [TIME_PORT_W-1:0]    etime;
        logic [PAYLOAD_PORT_W-1:0] payload;
    } t_frame_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [OP_W-1:0]           i_operation;
    logic [CH_PORT_W-1:0]      i_channel;
    logic [TIME_PORT_W-1:0]    i_timestamp;
    logic [PAYLOAD_PORT_W-1:0] i_payload_in;
    logic                      o_valid;
    logic                      i_stall;
    logic [STATUS_W-1:0]       o_status;
    logic [TIME_PORT_W-1:0]    o_entry_time;
    logic [PAYLOAD_PORT_W-1:0] o_payload_out;

    // shadow copy of the per-channel stacks
    logic [TIME_PORT_W-1:0]    shadow_time [NUM_CH][NUM_ENTRIES];
    logic [PAYLOAD_PORT_W-1:0] shadow_payload [NUM_CH][NUM_ENTRIES];
    int                        shadow_count [NUM_CH];
    int                        shadow_cursor [NUM_CH];

    t_frame_result pending_frames[$];
    int            mismatch_count = 0;
    bit            tx_quiet = 1'b0;
    bit            rx_quiet = 1'b0;
    int            hold_left = 0;

    timestamped_rewind_buffer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_channel    (i_channel),
        .i_timestamp  (i_timestamp),
        .i_payload_in (i_payload_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_entry_time (o_entry_time),
        .o_payload_out(o_payload_out)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_frame_result predict_frame(input logic [OP_W-1:0] op,
                                                    input logic [CH_PORT_W-1:0] ch,
                                                    input logic [TIME_PORT_W-1:0] ts,
                                                    input logic [PAYLOAD_PORT_W-1:0] pl);
        t_frame_result r;
        int n;
        int ic;
        r = '0;
        r.status = ST_NO_FRAME;
        if (op == OP_CLEAR) begin
            for (int c = 0; c < NUM_CH; c++) begin
                shadow_count[c] = 0;
                shadow_cursor[c] = 0;
            end
            r.status = ST_ACCEPTED;
        end else if (op == OP_UNUSED || int'(ch) >= NUM_CH) begin
            r.status = ST_NO_FRAME;
        end else if (op == OP_RECORD) begin
            n = shadow_count[ch];
            while (n > 0 && shadow_time[ch][n-1] >= ts)
                n--;
            shadow_count[ch] = n;
            if (n >= NUM_ENTRIES) begin
                r.status = ST_DROPPED;
            end else begin
                shadow_time[ch][n] = ts;
                shadow_payload[ch][n] = pl;
                shadow_count[ch] = n + 1;
                r.status = ST_ACCEPTED;
            end
        end else begin
            n = shadow_count[ch];
            ic = shadow_cursor[ch];
            if (ic > n - 1)
                ic = n - 1;
            shadow_cursor[ch] = ic;
            if (n >= 2) begin
                // walk up, never onto the last entry, then back down
                while (ic + 1 < n - 1 && shadow_time[ch][ic+1] <= ts)
                    ic++;
                while (ic > 0 && shadow_time[ch][ic] > ts)
                    ic--;
                shadow_cursor[ch] = ic;
                if (ic >= 0) begin
                    r.status = (ts <= shadow_time[ch][n-1]) ? ST_WITHIN : ST_PAST_END;
                    r.etime = shadow_time[ch][ic];
                    r.payload = shadow_payload[ch][ic];
                end
            end
        end
        return r;
    endfunction

    function automatic int idle_len(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_PORT_W-1:0] last_time(input logic [CH_PORT_W-1:0] ch);
        if (shadow_count[ch] == 0)
            return '0;
        return shadow_time[ch][shadow_count[ch]-1];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [CH_PORT_W-1:0] ch,
                             input logic [TIME_PORT_W-1:0] ts,
                             input logic [PAYLOAD_PORT_W-1:0] pl);
        int gap;
        gap = idle_len(tx_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_channel <= ch;
        i_timestamp <= ts;
        i_payload_in <= pl;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_frames.insert(pending_frames.size(), predict_frame(op, ch, ts, pl));
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_frames.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    // receiver: random stall runs, or a long hold-off when one is requested
    initial begin : rx_stall_gen
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0 && !rx_quiet) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (free_left > 0 || rx_quiet) begin
                i_stall <= 1'b0;
                if (free_left > 0)
                    free_left--;
            end else begin
                i_stall <= 1'b0;
                free_left = $urandom_range(0, 6);
                stall_left = idle_len(1'b0);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected result status", 64'(o_status), '0);
            end else begin
                want = pending_frames.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_entry_time !== want.etime)
                    report_mismatch("entry_time", 64'(o_entry_time), 64'(want.etime));
                if (o_payload_out !== want.payload)
                    report_mismatch("payload_out", o_payload_out, want.payload);
            end
        end
    end

    task automatic test_directed();
        send_beat(OP_PLAY, 0, 0, '0);             // empty: cursor drops to -1
        send_beat(OP_RECORD, 0, 10, '0);
        send_beat(OP_PLAY, 0, 10, '0);            // single entry
        send_beat(OP_RECORD, 0, 20, '1);
        send_beat(OP_RECORD, 0, 30, {$urandom, $urandom});
        send_beat(OP_PLAY, 0, 5, '0);             // cursor stuck at -1
        send_beat(OP_PLAY, 0, 25, '0);
        send_beat(OP_PLAY, 0, '1, '0);            // past end
        send_beat(OP_PLAY, 0, 15, '0);            // walk down
        send_beat(OP_RECORD, 0, 20, {$urandom, $urandom}); // equal time truncates
        send_beat(OP_RECORD, 0, '1, '1);
        send_beat(OP_PLAY, 0, '1, '0);
        send_beat(OP_RECORD, 0, 0, '0);           // truncates everything
        send_beat(OP_UNUSED, 1, $urandom, {$urandom, $urandom});
        send_beat(OP_RECORD, 3, 32'h8000_0000, {$urandom, $urandom});
        send_beat(OP_RECORD, 3, 32'hFFFF_FFFE, {$urandom, $urandom});
        send_beat(OP_PLAY, 3, 32'h8000_0000, '0);
        send_beat(OP_CLEAR, 2, $urandom, {$urandom, $urandom});
        send_beat(OP_PLAY, 3, 0, '0);
        send_beat(OP_RECORD, 1, 5, {$urandom, $urandom});
        send_beat(OP_RECORD, 1, 6, {$urandom, $urandom});
        send_beat(OP_PLAY, 1, 4, '0);             // query before first entry
        wait_drain();
    endtask

    task automatic test_deep_channel();
        send_beat(OP_CLEAR, 0, 0, '0);
        for (int i = 1; i <= DEEP_FILL; i++) begin
            tx_quiet = (i % 64) < 32;
            send_beat(OP_RECORD, 2, i * 4, {$urandom, $urandom});
        end
        tx_quiet = 1'b0;
        send_beat(OP_PLAY, 2, '1, '0);
        send_beat(OP_PLAY, 2, 0, '0);             // long walk down
        send_beat(OP_PLAY, 2, 250, '0);           // long walk up
        send_beat(OP_RECORD, 2, DEEP_FILL * 4, {$urandom, $urandom}); // replaces the last
        send_beat(OP_PLAY, 2, DEEP_FILL * 4, '0);
        send_beat(OP_RECORD, 2, 2, {$urandom, $urandom}); // truncates the whole stack
        send_beat(OP_CLEAR, 0, 0, '0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_quiet = 1'b1;
        @(posedge i_clk);
        hold_left = 400;
        for (int i = 0; i < 20; i++) begin
            if (i % 3 == 2)
                send_beat(OP_PLAY, 1, $urandom_range(0, 40), '0);
            else
                send_beat(OP_RECORD, 1, i * 3 + 1, {$urandom, $urandom});
        end
        tx_quiet = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_mix();
        logic [CH_PORT_W-1:0]   ch;
        logic [TIME_PORT_W-1:0] base_t;
        int r;
        for (int i = 0; i < 240; i++) begin
            if (i % 50 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            ch = CH_PORT_W'($urandom_range(0, NUM_CH - 1));
            base_t = last_time(ch);
            r = $urandom_range(0, 99);
            if (r < 2)
                send_beat(OP_CLEAR, ch, $urandom, {$urandom, $urandom});
            else if (r < 4)
                send_beat(OP_UNUSED, ch, $urandom, {$urandom, $urandom});
            else if (r < 45)
                send_beat(OP_RECORD, ch,
                          (shadow_count[ch] == 0) ? $urandom_range(0, 100)
                                                  : base_t + $urandom_range(1, 50),
                          {$urandom, $urandom});
            else if (r < 52)
                send_beat(OP_RECORD, ch, $urandom_range(0, base_t + 5),
                          {$urandom, $urandom});
            else if (r < 57)
                send_beat(OP_RECORD, ch, $urandom, {$urandom, $urandom});
            else if (r < 92)
                send_beat(OP_PLAY, ch, $urandom_range(0, base_t + 60),
                          {$urandom, $urandom});
            else
                send_beat(OP_PLAY, ch, $urandom, {$urandom, $urandom});
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_RECORD;
        i_channel = '0;
        i_timestamp = '0;
        i_payload_in = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            shadow_count[c] = 0;
            shadow_cursor[c] = 0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_deep_channel();
        test_backpressure();
        test_random_mix();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #4ms;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/trb_pkg.sv
rtl/trb_store.sv
rtl/trb_out.sv
rtl/trb_ctrl.sv
rtl/timestamped_rewind_buffer.sv
rtl/trb_checker.sv
sim/tb_timestamped_rewind_buffer.sv
